>>> rtl/sfir_pkg.sv
// Shared constants and payload types for the symmetric FIR filter.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package sfir_pkg;

  // Filter geometry
  localparam int TAPS        = 32;
  localparam int HALF_TAPS   = TAPS / 2;
  localparam int ADDR_W      = $clog2(TAPS);
  localparam int PAIR_W      = $clog2(HALF_TAPS);

  // Number formats
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_SHIFT  = COEF_BITS - 1;

  // Configuration port
  localparam int NUM_REGS    = 8;
  localparam int REG_SEL_W   = $clog2(NUM_REGS);
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // Digit-serial multiply: coefficient consumed DIGIT_W bits per cycle
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = COEF_BITS / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);
  localparam int PRE_W       = SAMPLE_BITS + 1;
  localparam int PSH_W       = PRE_W + DIGIT_W * (NUM_DIGITS - 1);
  localparam int PROD_W      = PSH_W + DIGIT_W + 1;
  localparam int ACC_W       = PRE_W + COEF_BITS + PAIR_W + 1;
  localparam int RND_W       = ACC_W - FRAC_SHIFT;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]         cfg_data_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

endpackage

`default_nettype wire

>>> rtl/sfir_in_if.sv
// Input sample channel: valid/ready plus one signed sample per word.
// Depends on sfir_pkg.
`default_nettype none

interface sfir_in_if;
  logic             valid;
  logic             ready;
  sfir_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

>>> rtl/sfir_out_if.sv
// Result channel: valid/ready plus filtered sample and saturation flag.
// Depends on sfir_pkg.
`default_nettype none

interface sfir_out_if;
  logic             valid;
  logic             ready;
  sfir_pkg::sample_t filtered;
  logic             saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink   (input valid, input filtered, input saturated, output ready);
endinterface

`default_nettype wire

>>> rtl/sfir_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on sfir_pkg.
`default_nettype none

interface sfir_cfg_if;
  logic               valid;
  logic               ready;
  sfir_pkg::cfg_idx_t  index;
  sfir_pkg::cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/symmetric_fir_filter.sv
// Top level of the 32-tap symmetric FIR filter: delay line, coefficient
// registers and the digit-serial pre-add multiply-accumulate sequencer.
// Depends on sfir_pkg, sfir_in_if, sfir_out_if and sfir_cfg_if.
//
// Each input word is written into a 32-entry circular delay line (a memory
// with registered reads and one valid bit per entry, so it reads as zero
// after reset without a clearing pass). The filter then walks the 16 tap
// pairs: for each it reads the two mirrored samples, pre-adds them, and
// then applies the 16-bit coefficient four bits at a time through a 29x5
// multiplier into a 38-bit accumulator. After the last pair the sum is
// rounded and saturated into the output register, as soon as that register
// has been emptied; only then does the filter return to idle and accept
// the next sample, so no sample is taken while a sum is in progress.
// A pending result does not block the next sample. Coefficient writes are
// taken every cycle and should only be issued while the filter is idle.
`default_nettype none

module symmetric_fir_filter (
  input  wire         clk,
  input  wire         rst_n,
  sfir_in_if.sink     in_ch,
  sfir_out_if.source  out_ch,
  sfir_cfg_if.sink    cfg_ch
);
  import sfir_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_PRE   = 5'b00100,
    S_MAC   = 5'b01000,
    S_ROUND = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        head_r;
  logic [PAIR_W-1:0]        pair_r;
  logic [DIGIT_CNT_W-1:0]   digit_r;
  logic [CFG_DATA_W-1:0]    coef_r [NUM_REGS];

  sample_t                  hist_mem [TAPS];
  logic [TAPS-1:0]          hist_vld_r;
  sample_t                  rd_new_r, rd_old_r;
  logic                     rd_new_vld_r, rd_old_vld_r;

  logic signed [PSH_W-1:0]  pre_sh_r;
  logic [COEF_BITS-1:0]     coef_sh_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                     out_valid_r;
  sample_t                  filtered_r;
  logic                     sat_r;

  logic                     in_acc, out_free;
  logic                     last_pair, last_digit;
  logic [ADDR_W-1:0]        addr_new, addr_old;
  coef_t                    coef_sel;
  sample_t                  new_s, old_s;
  logic signed [PRE_W-1:0]  pre_sum;
  logic signed [DIGIT_W:0]  dig_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  rnd_sum;
  logic signed [RND_W-1:0]  y_full;
  logic                     ovf;

  // Handshakes
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign last_pair  = (pair_r == PAIR_W'(HALF_TAPS - 1));
  assign last_digit = (digit_r == DIGIT_CNT_W'(NUM_DIGITS - 1));

  // Mirrored read addresses: newest side x[n-i], oldest side x[n-(TAPS-1-i)]
  assign addr_new = head_r - ADDR_W'(pair_r);
  assign addr_old = head_r + ADDR_W'(1) + ADDR_W'(pair_r);

  // Coefficient of the current pair: low half for even pairs, high for odd
  always_comb begin
    logic [CFG_DATA_W-1:0] word;
    word = coef_r[pair_r[PAIR_W-1:1]];
    coef_sel = pair_r[0] ? coef_t'(word[2*COEF_BITS-1:COEF_BITS])
                         : coef_t'(word[COEF_BITS-1:0]);
  end

  // Pre-add; entries never written read as zero
  assign new_s   = rd_new_vld_r ? rd_new_r : '0;
  assign old_s   = rd_old_vld_r ? rd_old_r : '0;
  assign pre_sum = PRE_W'(new_s) + PRE_W'(old_s);

  // Digit multiply: lower digits unsigned, top digit carries the sign
  assign dig_s = last_digit ? (DIGIT_W+1)'($signed(coef_sh_r[DIGIT_W-1:0]))
                            : $signed({1'b0, coef_sh_r[DIGIT_W-1:0]});
  assign prod  = PROD_W'(pre_sh_r) * PROD_W'(dig_s);

  // Round to nearest (ties up), then clamp
  assign rnd_sum = acc_r + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
  assign y_full  = RND_W'(rnd_sum >>> FRAC_SHIFT);
  assign ovf     = (y_full[RND_W-1:SAMPLE_BITS-1] != '0) &&
                   (y_full[RND_W-1:SAMPLE_BITS-1] != '1);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_READ;
      S_READ:  state_nxt = S_PRE;
      S_PRE:   state_nxt = S_MAC;
      S_MAC:   if (last_digit) state_nxt = last_pair ? S_ROUND : S_READ;
      S_ROUND: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      pair_r      <= '0;
      digit_r     <= '0;
      hist_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        hist_vld_r[head_r] <= 1'b1;
        pair_r             <= '0;
      end
      if (state_r == S_PRE) digit_r <= '0;
      if (state_r == S_MAC) begin
        digit_r <= digit_r + DIGIT_CNT_W'(1);
        if (last_digit) pair_r <= pair_r + PAIR_W'(1);
      end
      if (state_r == S_ROUND && out_free) begin
        head_r      <= head_r + ADDR_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_REGS; k++) coef_r[k] <= '0;
    end else if (cfg_ch.valid && cfg_ch.index < CFG_IDX_W'(NUM_REGS)) begin
      coef_r[cfg_ch.index[REG_SEL_W-1:0]] <= cfg_ch.data;
    end
  end

  // Delay line memory and its valid bits at the read ports
  always_ff @(posedge clk) begin
    if (in_acc) hist_mem[head_r] <= in_ch.sample_in;
    if (state_r == S_READ) begin
      rd_new_r     <= hist_mem[addr_new];
      rd_old_r     <= hist_mem[addr_old];
      rd_new_vld_r <= hist_vld_r[addr_new];
      rd_old_vld_r <= hist_vld_r[addr_old];
    end
  end

  // Datapath: pre-add, digit shift registers, accumulator, output word
  always_ff @(posedge clk) begin
    if (in_acc) acc_r <= '0;
    if (state_r == S_PRE) begin
      pre_sh_r  <= PSH_W'(pre_sum);
      coef_sh_r <= coef_sel;
    end
    if (state_r == S_MAC) begin
      acc_r     <= acc_r + ACC_W'(prod);
      pre_sh_r  <= pre_sh_r <<< DIGIT_W;
      coef_sh_r <= coef_sh_r >> DIGIT_W;
    end
    if (state_r == S_ROUND && out_free) begin
      sat_r      <= ovf;
      filtered_r <= ovf ? (y_full[RND_W-1] ? SAMPLE_MIN : SAMPLE_MAX)
                        : sample_t'(y_full[SAMPLE_BITS-1:0]);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.filtered  = filtered_r;
  assign out_ch.saturated = sat_r;

endmodule

`default_nettype wire

>>> rtl/sfir_checker.sv
// Port-level checks for the symmetric FIR filter, attached by bind.
// Depends on sfir_pkg and the symmetric_fir_filter top level.
`default_nettype none

module sfir_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_valid,
  input wire                    in_ready,
  input wire                    out_valid,
  input wire                    out_ready,
  input wire sfir_pkg::sample_t filtered,
  input wire                    saturated
);
  import sfir_pkg::*;

  // A held result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // A held result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(filtered) && $stable(saturated))
    else $error("result word changed while stalled");

  // Saturation flag only with a clamped value
  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |-> filtered == SAMPLE_MAX || filtered == SAMPLE_MIN)
    else $error("saturated flag set on an unclamped value");

  // A sample is never taken while the MAC pass runs: no two samples on consecutive edges
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while a sum is in progress");

endmodule

bind symmetric_fir_filter sfir_checker u_sfir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .filtered  (out_ch.filtered),
  .saturated (out_ch.saturated)
);

`default_nettype wire
